// ===== sv/lub_alloc_pkg.sv =====
// ----------------------------------------------------------------------------
// lub_alloc_pkg
// Sizes, derived widths, masks and codes shared by the least-used-bank bump allocator.
// ----------------------------------------------------------------------------
package lub_alloc_pkg;

    localparam int NUM_BANKS      = 4;
    localparam int BANK_SIZE_LOG2 = 34;
    localparam int ALIGN_LOG2     = 12;

    // Fixed field widths of the request and result beats.
    localparam int CMD_W  = 1;
    localparam int BANK_W = 3;
    localparam int SIZE_W = 35;
    localparam int ADDR_W = 36;

    // Derived widths.
    localparam int FILL_W  = BANK_SIZE_LOG2;
    localparam int SEL_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int ALGN_W  = FILL_W + 1;
    localparam int SUM_W   = ((ALGN_W > SIZE_W) ? ALGN_W : SIZE_W) + 1;
    localparam int GADDR_W = SEL_W + FILL_W;

    localparam logic [ALGN_W-1:0] ALIGN_MASK = ALGN_W'((64'd1 << ALIGN_LOG2) - 64'd1);
    localparam logic [ADDR_W-1:0] ADDR_ALIGN_MASK =
        ADDR_W'((64'd1 << ALIGN_LOG2) - 64'd1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_AUTO  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_NAMED = 1'b1;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef logic [FILL_W-1:0] t_fill;

endpackage

// ===== sv/least_used_bank_bump_allocator.sv =====
// ----------------------------------------------------------------------------
// least_used_bank_bump_allocator
// Bump allocator over equal banks; picks a named bank or the least filled one,
// aligns its fill mark and returns the global address of the new block.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | flow
//  ----------+-----------------------------------------+----------------------
//  request   | start, busy, i_cmd, i_bank, i_size_bytes| beat when start & !busy
//  result    | o_valid, o_status, o_address            | one-cycle strobe
//
//  A request beat is registered at the edge that takes it; the next cycle
//  selects the bank, aligns, checks room and updates the fill mark, and the
//  result is registered and shows on o_valid in the cycle after that.
//  busy stays low, so one beat can be taken every cycle; the fill update
//  lands in the same edge that registers the following request.
//  Synchronous active-low reset clears all fill marks and the valid flags.
//  The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module least_used_bank_bump_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lub_alloc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [lub_alloc_pkg::BANK_W-1:0]  i_bank,
    input  logic [lub_alloc_pkg::SIZE_W-1:0]  i_size_bytes,
    output logic                              o_valid,
    output logic                              o_status,
    output logic [lub_alloc_pkg::ADDR_W-1:0]  o_address
);
    import lub_alloc_pkg::*;

    // Request register.
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [BANK_W-1:0] r_bank;
    logic [SIZE_W-1:0] r_size;

    // Fill marks.
    t_fill r_fill [NUM_BANKS];
    t_fill n_fill [NUM_BANKS];

    // Result register.
    logic              r_out_valid;
    logic              r_status;
    logic [ADDR_W-1:0] r_address;
    logic              n_status;
    logic [ADDR_W-1:0] n_address;

    logic [SEL_W-1:0]          w_least;
    logic [SEL_W-1:0]          w_sel;
    logic                      w_bad;
    logic                      w_fits;
    logic                      w_commit;
    logic [ALGN_W-1:0]         w_aligned;
    logic [SUM_W-1:0]          w_sum;
    logic [GADDR_W-1:0]        w_gaddr;
    logic [GADDR_W+ADDR_W-1:0] w_gaddr_ext;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_cmd  <= i_cmd;
            r_bank <= i_bank;
            r_size <= i_size_bytes;
        end
    end

    // Least filled bank; strict compare keeps the lowest index on a tie.
    always_comb begin
        w_least = '0;
        for (int b = 1; b < NUM_BANKS; b++) begin
            if (r_fill[b] < r_fill[w_least]) begin
                w_least = SEL_W'(b);
            end
        end
    end

    always_comb begin
        w_bad = (r_cmd == CMD_NAMED) && ({1'b0, r_bank} >= (BANK_W+1)'(NUM_BANKS));
        if (r_cmd == CMD_NAMED && !w_bad) begin
            w_sel = r_bank[SEL_W-1:0];
        end else if (r_cmd == CMD_NAMED) begin
            w_sel = '0;
        end else begin
            w_sel = w_least;
        end

        w_aligned   = ({1'b0, r_fill[w_sel]} + ALIGN_MASK) & ~ALIGN_MASK;
        w_sum       = SUM_W'(w_aligned) + SUM_W'(r_size);
        w_fits      = (w_sum[SUM_W-1:FILL_W] == '0);
        w_commit    = r_in_valid && !w_bad && w_fits;
        w_gaddr     = {w_sel, w_aligned[FILL_W-1:0]};
        w_gaddr_ext = {{ADDR_W{1'b0}}, w_gaddr};

        if (!w_bad && w_fits) begin
            n_status  = STATUS_OK;
            n_address = w_gaddr_ext[ADDR_W-1:0];
        end else begin
            n_status  = STATUS_FAIL;
            n_address = '0;
        end

        for (int b = 0; b < NUM_BANKS; b++) begin
            n_fill[b] = r_fill[b];
            if (w_commit && w_sel == SEL_W'(b)) begin
                n_fill[b] = w_sum[FILL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_fill[b] <= '0;
            end
        end else begin
            r_out_valid <= r_in_valid;
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_fill[b] <= n_fill[b];
            end
        end
        r_status  <= n_status;
        r_address <= n_address;
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_address = r_address;

    // A failed allocation never reports an address.
    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_FAIL |-> o_address == '0)
        else $error("failed allocation carries a nonzero address");

    // Every granted address sits on an alignment boundary.
    a_aligned : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_OK |-> (o_address & ADDR_ALIGN_MASK) == '0)
        else $error("granted address is not aligned");

    // A request that names a missing bank must fail in the next cycle.
    a_bad_bank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_bad |=> o_valid && o_status == STATUS_FAIL)
        else $error("request for a missing bank did not fail");

    // Nothing is ever freed, so no fill mark moves backward.
    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_mono
        a_fill_mono : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            $past(i_rst_n) |-> r_fill[g] >= $past(r_fill[g]))
            else $error("fill mark decreased");
    end

endmodule
